// File: rtl/pmx_pkg.sv
`default_nettype none
package pmx_pkg;

    localparam int GENE_W = 6;
    localparam int CNT_W = 7;
    localparam int GENE_SPACE = 64;

    // one pair of parents, ready to be processed
    typedef struct packed {
        logic              err;
        logic [GENE_W-1:0] start;
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  n;
    } job_t;

    // parent store write from the loader
    typedef struct packed {
        logic              en;
        logic [CNT_W-1:0]  addr;
        logic [GENE_W-1:0] a;
        logic [GENE_W-1:0] b;
    } par_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG_RD,
        ST_SEG_WR,
        ST_W_RD,
        ST_W_LD,
        ST_WA_CHK,
        ST_WA_NXT,
        ST_WB_CHK,
        ST_WB_NXT,
        ST_EMIT,
        ST_ERR
    } back_state_t;

endpackage
`default_nettype wire

// File: rtl/pmx_front.sv
`default_nettype none
module pmx_front #(
    parameter int NCAP = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [6:0]                  vertex_count,
    input  wire logic [5:0]                  gene_a,
    input  wire logic [5:0]                  gene_b,
    input  wire logic [5:0]                  segment_start,
    input  wire logic [6:0]                  segment_length,
    output pmx_pkg::par_wr_t                 par_wr,
    output logic                             push,
    output pmx_pkg::job_t                    job
);
    import pmx_pkg::*;

    localparam logic [CNT_W-1:0] NCAP_C = CNT_W'(NCAP);

    logic [CNT_W-1:0] load_count_reg, load_count_next;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] pos_inc;

    // clamp the vertex count
    always_comb
    begin
        if (vertex_count < CNT_W'(2))
            n_eff = CNT_W'(2);
        else if (vertex_count > NCAP_C)
            n_eff = NCAP_C;
        else
            n_eff = vertex_count;
    end

    assign pos_inc = load_count_reg + CNT_W'(1);

    // store the pair and close the request on the last position
    always_comb
    begin
        par_wr.en   = accept && (load_count_reg < n_eff);
        par_wr.addr = load_count_reg;
        par_wr.a    = gene_a;
        par_wr.b    = gene_b;
        push        = accept && !(pos_inc < n_eff);
        job.err     = {1'b0, segment_start} >= n_eff;
        job.start   = segment_start;
        job.len     = (segment_length > n_eff) ? n_eff : segment_length;
        job.n       = n_eff;
        load_count_next = load_count_reg;
        if (accept)
            load_count_next = push ? '0 : pos_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_count_reg <= '0;
        else
            load_count_reg <= load_count_next;
    end

endmodule
`default_nettype wire

// File: rtl/pmx_job_queue.sv
`default_nettype none
module pmx_job_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  pmx_pkg::job_t      push_job,
    input  wire logic          pop,
    output logic               empty,
    output pmx_pkg::job_t      head
);
    import pmx_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign empty   = (count_reg == 2'd0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && !empty;
    assign do_push = push && (count_reg != 2'd2);

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

// File: rtl/pmx_back.sv
`default_nettype none
module pmx_back #(
    parameter int NCAP = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  pmx_pkg::par_wr_t   par_wr,
    input  wire logic          job_avail,
    input  pmx_pkg::job_t      job_in,
    output logic               pop,
    output logic               back_busy,
    output logic               result_valid,
    output logic [5:0]         child_a_gene,
    output logic [5:0]         child_b_gene,
    output logic [5:0]         position,
    output logic               last,
    output logic               error
);
    import pmx_pkg::*;

    localparam int AW = $clog2(NCAP);

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [CNT_W-1:0] idx_reg, idx_next, cnt_reg, cnt_next, pos_reg, pos_next;
    logic [CNT_W-1:0] steps_reg, steps_next, emit_reg, emit_next;
    logic [GENE_W-1:0] va_reg, va_next, vb_reg, vb_next;

    // stores
    logic [GENE_W-1:0] pa_mem [NCAP];
    logic [GENE_W-1:0] pb_mem [NCAP];
    logic [GENE_W-1:0] ma_mem [GENE_SPACE];
    logic [GENE_W-1:0] mb_mem [GENE_SPACE];
    logic [GENE_W-1:0] ca_mem [NCAP];
    logic [GENE_W-1:0] cb_mem [NCAP];
    logic [GENE_SPACE-1:0] ma_vld_reg, mb_vld_reg;
    logic [NCAP-1:0]       in_seg_reg;
    logic [GENE_W-1:0] pa_q, pb_q, ma_q, mb_q, ca_q, cb_q;

    // result registers
    logic             res_vld_reg, res_vld_next, res_last_reg, res_last_next;
    logic             res_err_reg, res_err_next;
    logic [GENE_W-1:0] res_pos_reg, res_pos_next;

    // control strobes
    logic [CNT_W-1:0] par_addr;
    logic             clear_maps, seg_wr, ca_wr, cb_wr;
    logic [CNT_W-1:0] idx_inc;

    assign idx_inc = idx_reg + CNT_W'(1);

    // sequencer: segment copy, chain walks, emission, error result
    always_comb
    begin
        state_next    = state_reg;
        job_next      = job_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        steps_next    = steps_reg;
        emit_next     = emit_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        res_vld_next  = 1'b0;
        res_last_next = 1'b0;
        res_err_next  = 1'b0;
        res_pos_next  = res_pos_reg;
        par_addr      = pos_reg;
        clear_maps    = 1'b0;
        seg_wr        = 1'b0;
        ca_wr         = 1'b0;
        cb_wr         = 1'b0;
        pop           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_avail)
                begin
                    pop        = 1'b1;
                    clear_maps = 1'b1;
                    job_next   = job_in;
                    idx_next   = {1'b0, job_in.start};
                    cnt_next   = '0;
                    pos_next   = '0;
                    if (job_in.err)
                        state_next = ST_ERR;
                    else if (job_in.len == '0)
                        state_next = ST_W_RD;
                    else
                        state_next = ST_SEG_RD;
                end
            end
            ST_SEG_RD:
            begin
                par_addr   = idx_reg;
                state_next = ST_SEG_WR;
            end
            ST_SEG_WR:
            begin
                seg_wr   = 1'b1;
                idx_next = (idx_inc == job_reg.n) ? '0 : idx_inc;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_next == job_reg.len)
                    state_next = ST_W_RD;
                else
                    state_next = ST_SEG_RD;
            end
            ST_W_RD:
            begin
                if (pos_reg == job_reg.n)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT;
                end
                else if (in_seg_reg[pos_reg[AW-1:0]])
                    pos_next = pos_reg + CNT_W'(1);
                else
                    state_next = ST_W_LD;
            end
            ST_W_LD:
            begin
                va_next    = pa_q;
                vb_next    = pb_q;
                steps_next = '0;
                state_next = ST_WA_CHK;
            end
            ST_WA_CHK:
            begin
                if (!ma_vld_reg[va_reg])
                begin
                    ca_wr      = 1'b1;
                    steps_next = '0;
                    state_next = ST_WB_CHK;
                end
                else if (steps_reg >= job_reg.n)
                    state_next = ST_ERR;
                else
                    state_next = ST_WA_NXT;
            end
            ST_WA_NXT:
            begin
                va_next    = ma_q;
                steps_next = steps_reg + CNT_W'(1);
                state_next = ST_WA_CHK;
            end
            ST_WB_CHK:
            begin
                if (!mb_vld_reg[vb_reg])
                begin
                    cb_wr      = 1'b1;
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = ST_W_RD;
                end
                else if (steps_reg >= job_reg.n)
                    state_next = ST_ERR;
                else
                    state_next = ST_WB_NXT;
            end
            ST_WB_NXT:
            begin
                vb_next    = mb_q;
                steps_next = steps_reg + CNT_W'(1);
                state_next = ST_WB_CHK;
            end
            ST_EMIT:
            begin
                res_vld_next  = 1'b1;
                res_pos_next  = emit_reg[GENE_W-1:0];
                emit_next     = emit_reg + CNT_W'(1);
                res_last_next = (emit_next == job_reg.n);
                if (res_last_next)
                    state_next = ST_IDLE;
            end
            ST_ERR:
            begin
                res_vld_next  = 1'b1;
                res_last_next = 1'b1;
                res_err_next  = 1'b1;
                res_pos_next  = '0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (par_wr.en)
        begin
            pa_mem[par_wr.addr[AW-1:0]] <= par_wr.a;
            pb_mem[par_wr.addr[AW-1:0]] <= par_wr.b;
        end
        pa_q <= pa_mem[par_addr[AW-1:0]];
        pb_q <= pb_mem[par_addr[AW-1:0]];
        if (seg_wr)
        begin
            ma_mem[pb_q] <= pa_q;
            mb_mem[pa_q] <= pb_q;
        end
        ma_q <= ma_mem[va_reg];
        mb_q <= mb_mem[vb_reg];
        if (seg_wr)
        begin
            ca_mem[idx_reg[AW-1:0]] <= pb_q;
            cb_mem[idx_reg[AW-1:0]] <= pa_q;
        end
        else
        begin
            if (ca_wr)
                ca_mem[pos_reg[AW-1:0]] <= va_reg;
            if (cb_wr)
                cb_mem[pos_reg[AW-1:0]] <= vb_reg;
        end
        ca_q <= ca_mem[emit_reg[AW-1:0]];
        cb_q <= cb_mem[emit_reg[AW-1:0]];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        job_reg     <= job_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        pos_reg     <= pos_next;
        steps_reg   <= steps_next;
        emit_reg    <= emit_next;
        va_reg      <= va_next;
        vb_reg      <= vb_next;
        res_pos_reg <= res_pos_next;
        res_last_reg <= res_last_next;
        res_err_reg <= res_err_next;
    end

    // control state, result valid, map valid and segment bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            res_vld_reg <= 1'b0;
            ma_vld_reg  <= '0;
            mb_vld_reg  <= '0;
            in_seg_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            res_vld_reg <= res_vld_next;
            if (clear_maps)
            begin
                ma_vld_reg <= '0;
                mb_vld_reg <= '0;
                in_seg_reg <= '0;
            end
            else if (seg_wr)
            begin
                ma_vld_reg[pb_q] <= 1'b1;
                mb_vld_reg[pa_q] <= 1'b1;
                in_seg_reg[idx_reg[AW-1:0]] <= 1'b1;
            end
        end
    end

    assign back_busy    = (state_reg != ST_IDLE);
    assign result_valid = res_vld_reg;
    assign child_a_gene = res_err_reg ? '0 : ca_q;
    assign child_b_gene = res_err_reg ? '0 : cb_q;
    assign position     = res_pos_reg;
    assign last         = res_last_reg;
    assign error        = res_err_reg;

endmodule
`default_nettype wire

// File: rtl/partially_mapped_crossover_unit.sv
// Partially mapped crossover of two parent permutations. Each request on
// start/busy carries one position's genes of both parents; the request for
// the last position (clamped vertex_count of them) also gives the circular
// segment. Positions load at one per cycle while busy is low. The pair is then
// processed: it is taken from the queue, the segment positions are copied,
// then a pass over all positions skips each segment position and repairs each
// position outside the segment by walking the chains of A and B through the
// map memory read port. After that the children come out one position per
// cycle on result_valid. busy stays high from the last position until the
// final result of the pair is on the ports. Results cannot be held off by the
// receiver. An out-of-range start or a chain that does not end gives a single
// result with error set.
`default_nettype none
module partially_mapped_crossover_unit #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [5:0] gene_a,
    input  wire logic [5:0] gene_b,
    input  wire logic [5:0] segment_start,
    input  wire logic [6:0] segment_length,
    output logic            result_valid,
    output logic [5:0]      child_a_gene,
    output logic [5:0]      child_b_gene,
    output logic [5:0]      position,
    output logic            last,
    output logic            error
);
    import pmx_pkg::*;

    localparam int NCAP = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;

    logic [6:0] vertex_count_reg;
    logic       accept, push, q_empty, pop, back_busy;
    par_wr_t    par_wr;
    job_t       job, head;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= 7'd64;
        else if (cfg_we)
            vertex_count_reg <= cfg_wdata;
    end

    assign busy   = !q_empty || back_busy;
    assign accept = start && !busy;

    pmx_front #(.NCAP(NCAP)) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .vertex_count   (vertex_count_reg),
        .gene_a         (gene_a),
        .gene_b         (gene_b),
        .segment_start  (segment_start),
        .segment_length (segment_length),
        .par_wr         (par_wr),
        .push           (push),
        .job            (job)
    );

    pmx_job_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .empty    (q_empty),
        .head     (head)
    );

    pmx_back #(.NCAP(NCAP)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .par_wr       (par_wr),
        .job_avail    (!q_empty),
        .job_in       (head),
        .pop          (pop),
        .back_busy    (back_busy),
        .result_valid (result_valid),
        .child_a_gene (child_a_gene),
        .child_b_gene (child_b_gene),
        .position     (position),
        .last         (last),
        .error        (error)
    );

    // checks
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && error |-> last)
        else $error("error result without last");
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid && !error)
        else $error("child emission broken");
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> position == $past(position) + 6'd1)
        else $error("position not sequential");
    a_busy_last: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> busy)
        else $error("not busy after pair completed");

endmodule
`default_nettype wire

// File: verif/pmx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module pmx_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [pmx_pkg::CNT_W-1:0]  cfg_wdata,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic [pmx_pkg::GENE_W-1:0] gene_a,
    input  wire logic [pmx_pkg::GENE_W-1:0] gene_b,
    input  wire logic [pmx_pkg::GENE_W-1:0] segment_start,
    input  wire logic [pmx_pkg::CNT_W-1:0]  segment_length,
    input  wire logic                       result_valid,
    input  wire logic [pmx_pkg::GENE_W-1:0] child_a_gene,
    input  wire logic [pmx_pkg::GENE_W-1:0] child_b_gene,
    input  wire logic [pmx_pkg::GENE_W-1:0] position,
    input  wire logic                       last,
    input  wire logic                       error,
    output int                              fails,
    output int                              pending,
    output int                              children_seen,
    output int                              errors_seen
);
    import pmx_pkg::*;

    localparam logic [CNT_W-1:0] MAP_VALID = 7'h40;
    localparam int MAX_GENES = 64;

    typedef struct packed {
        logic [GENE_W-1:0] ca;
        logic [GENE_W-1:0] cb;
        logic [GENE_W-1:0] pos;
        logic              last;
        logic              err;
    } child_t;

    typedef logic [CNT_W-1:0] gene_map_t [GENE_SPACE];

    // shadow of the block's state
    logic [CNT_W-1:0]  vcount;
    int                loaded;
    logic [GENE_W-1:0] par_a [MAX_GENES];
    logic [GENE_W-1:0] par_b [MAX_GENES];
    child_t            expected_children[$];

    assign pending = expected_children.size();

    function automatic int clamp_count(logic [CNT_W-1:0] v);
        if (v < 2) return 2;
        if (v > MAX_GENES) return MAX_GENES;
        return int'(v);
    endfunction

    // follow a value map until unmapped; returns 0 if it does not end in n steps
    function automatic bit follow_map(gene_map_t m, logic [GENE_W-1:0] from, int n,
                                      output logic [GENE_W-1:0] to);
        logic [GENE_W-1:0] v;
        int steps;
        v = from;
        steps = 0;
        while (m[v][6]) begin
            if (steps >= n) return 0;
            v = m[v][GENE_W-1:0];
            steps++;
        end
        to = v;
        return 1;
    endfunction

    task automatic push_error();
        child_t c;
        c = '0;
        c.last = 1'b1;
        c.err = 1'b1;
        expected_children.insert(expected_children.size(), c);
    endtask

    // one accepted request: store genes, and on the last position build both children
    task automatic crossover_request();
        int n, pos, s, len, idx;
        gene_map_t map_a, map_b;
        bit in_seg [MAX_GENES];
        logic [GENE_W-1:0] ca [MAX_GENES];
        logic [GENE_W-1:0] cb [MAX_GENES];
        child_t c;
        bit ok;
        n = clamp_count(vcount);
        pos = loaded;
        if (pos < n) begin
            par_a[pos] = gene_a;
            par_b[pos] = gene_b;
        end
        pos++;
        if (pos < n) begin
            loaded = pos;
            return;
        end
        loaded = 0;
        s = int'(segment_start);
        len = int'(segment_length);
        if (s >= n) begin
            push_error();
            return;
        end
        if (len > n) len = n;
        for (int i = 0; i < GENE_SPACE; i++) begin
            map_a[i] = '0;
            map_b[i] = '0;
        end
        for (int i = 0; i < MAX_GENES; i++) in_seg[i] = 0;
        // exchanged segment, later writes win
        for (int i = 0; i < len; i++) begin
            idx = (s + i) % n;
            in_seg[idx] = 1;
            ca[idx] = par_b[idx];
            cb[idx] = par_a[idx];
            map_a[par_b[idx]] = MAP_VALID | CNT_W'(par_a[idx]);
            map_b[par_a[idx]] = MAP_VALID | CNT_W'(par_b[idx]);
        end
        // repair positions outside the segment
        for (int i = 0; i < n; i++) begin
            if (!in_seg[i]) begin
                ok = follow_map(map_a, par_a[i], n, ca[i]);
                if (ok) ok = follow_map(map_b, par_b[i], n, cb[i]);
                if (!ok) begin
                    push_error();
                    return;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            c.ca = ca[i];
            c.cb = cb[i];
            c.pos = GENE_W'(i);
            c.last = (i + 1 == n);
            c.err = 1'b0;
            expected_children.insert(expected_children.size(), c);
        end
    endtask

    // compare results, then predict new requests
    always @(posedge clk or negedge rst_n) begin
        child_t want, got;
        if (!rst_n) begin
            vcount = 7'd64;
            loaded = 0;
            expected_children.delete();
            fails = 0;
            children_seen = 0;
            errors_seen = 0;
        end else begin
            if (result_valid) begin
                got = '{child_a_gene, child_b_gene, position, last, error};
                children_seen++;
                if (error) errors_seen++;
                if (expected_children.size() == 0) begin
                    if (fails < 10)
                        $display("[%0t] unexpected result ca=%0d cb=%0d pos=%0d last=%0b err=%0b",
                                 $time, got.ca, got.cb, got.pos, got.last, got.err);
                    fails++;
                end else begin
                    want = expected_children.pop_front();
                    if (got.ca !== want.ca || got.cb !== want.cb || got.pos !== want.pos ||
                        got.last !== want.last || got.err !== want.err) begin
                        if (fails < 10)
                            $display({"[%0t] child mismatch exp ca=%0d cb=%0d pos=%0d last=%0b",
                                      " err=%0b / got ca=%0d cb=%0d pos=%0d last=%0b err=%0b"},
                                     $time, want.ca, want.cb, want.pos, want.last, want.err,
                                     got.ca, got.cb, got.pos, got.last, got.err);
                        fails++;
                    end
                end
            end
            // a request at this edge still sees the old count
            if (start && !busy) crossover_request();
            if (cfg_we) vcount = cfg_wdata;
        end
    end

endmodule
`default_nettype wire

// File: verif/tb_partially_mapped_crossover_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_partially_mapped_crossover_unit;
    import pmx_pkg::*;

    localparam int ITEM_TARGET = 430;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_wdata;
    logic              start;
    logic              busy;
    logic [GENE_W-1:0] gene_a;
    logic [GENE_W-1:0] gene_b;
    logic [GENE_W-1:0] segment_start;
    logic [CNT_W-1:0]  segment_length;
    logic              result_valid;
    logic [GENE_W-1:0] child_a_gene;
    logic [GENE_W-1:0] child_b_gene;
    logic [GENE_W-1:0] position;
    logic              last;
    logic              error;
    int                fails, pending, children_seen, errors_seen;

    int                items_sent;
    int                pairs_sent;
    int                stall_cycles = 0;
    bit                gaps_on;
    logic [GENE_W-1:0] pa [64];
    logic [GENE_W-1:0] pb [64];

    partially_mapped_crossover_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .gene_a(gene_a), .gene_b(gene_b),
        .segment_start(segment_start), .segment_length(segment_length),
        .result_valid(result_valid), .child_a_gene(child_a_gene),
        .child_b_gene(child_b_gene), .position(position), .last(last), .error(error)
    );

    pmx_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .gene_a(gene_a), .gene_b(gene_b),
        .segment_start(segment_start), .segment_length(segment_length),
        .result_valid(result_valid), .child_a_gene(child_a_gene),
        .child_b_gene(child_b_gene), .position(position), .last(last), .error(error),
        .fails(fails), .pending(pending), .children_seen(children_seen),
        .errors_seen(errors_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one request; returns at the edge where it is taken
    task automatic send_gene(logic [GENE_W-1:0] a, logic [GENE_W-1:0] b,
                             logic [GENE_W-1:0] s, logic [CNT_W-1:0] l);
        if (gaps_on && items_sent < ITEM_TARGET - 60 && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start <= 1'b1;
        gene_a <= a;
        gene_b <= b;
        segment_start <= s;
        segment_length <= l;
        forever
        begin
            @(negedge clk);
            if (!busy) break;
        end
        @(posedge clk);
        items_sent++;
    endtask

    // load pa/pb for n positions; segment fields only matter on the last one
    task automatic send_pair(int n, logic [GENE_W-1:0] s, logic [CNT_W-1:0] l);
        for (int i = 0; i < n - 1; i++)
            send_gene(pa[i], pb[i], GENE_W'($urandom), CNT_W'($urandom));
        send_gene(pa[n-1], pb[n-1], s, l);
        pairs_sent++;
    endtask

    // sender holds off until every child is out and the block has settled
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // pa/pb become shuffled permutations of 0..n-1, or of distinct values from 0..63
    task automatic make_perms(int n, bit wide);
        logic [GENE_W-1:0] pool [64];
        logic [GENE_W-1:0] t;
        int j;
        for (int i = 0; i < 64; i++) pool[i] = GENE_W'(i);
        for (int i = 63; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = pool[i]; pool[i] = pool[j]; pool[j] = t;
        end
        for (int i = 0; i < 64; i++) pa[i] = wide ? pool[i] : GENE_W'(i);
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = pa[i]; pa[i] = pa[j]; pa[j] = t;
        end
        for (int i = 0; i < n; i++) pb[i] = pa[i];
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = pb[i]; pb[i] = pb[j]; pb[j] = t;
        end
    endtask

    initial
    begin
        int n, raw;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        start = 1'b0;
        gene_a = '0;
        gene_b = '0;
        segment_start = '0;
        segment_length = '0;
        items_sent = 0;
        pairs_sent = 0;
        gaps_on = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full pair at the reset count fills every parent entry; extreme genes
        make_perms(64, 0);
        pa[0] = 6'd63; pa[63] = 6'd0;
        send_pair(64, 6'd60, 7'd10);
        drain();

        // small count: empty, full, wrapped and oversize segments
        write_count(7'd4);
        make_perms(4, 0);
        send_pair(4, 6'd0, 7'd0);
        send_pair(4, 6'd0, 7'd4);
        send_pair(4, 6'd3, 7'd2);
        send_pair(4, 6'd1, 7'd64);
        // start out of range, at the count and at the top
        send_pair(4, 6'd4, 7'd2);
        send_pair(4, 6'd63, 7'd127);
        // map cycle from duplicated genes: no chain end
        pa[0] = 6'd0; pa[1] = 6'd1; pa[2] = 6'd0; pa[3] = 6'd3;
        pb[0] = 6'd1; pb[1] = 6'd0; pb[2] = 6'd2; pb[3] = 6'd3;
        send_pair(4, 6'd0, 7'd2);
        // genes beyond the count used as they are
        pa[0] = 6'd63; pa[1] = 6'd10; pa[2] = 6'd2; pa[3] = 6'd33;
        pb[0] = 6'd33; pb[1] = 6'd63; pb[2] = 6'd10; pb[3] = 6'd2;
        send_pair(4, 6'd1, 7'd2);
        drain();

        // count lowered in the middle of a load: next request closes the pair
        write_count(7'd8);
        make_perms(8, 0);
        for (int i = 0; i < 5; i++) send_gene(pa[i], pb[i], 6'd0, 7'd0);
        drain();
        write_count(7'd3);
        send_gene(6'd7, 6'd5, 6'd1, 7'd1);
        drain();

        // below-minimum counts clamp to two
        write_count(7'd0);
        make_perms(2, 0);
        send_pair(2, 6'd1, 7'd1);
        drain();
        write_count(7'd1);
        send_pair(2, 6'd0, 7'd2);
        drain();

        // random phases over several counts
        while (items_sent < ITEM_TARGET)
        begin
            raw = $urandom_range(0, 19);
            if (raw == 0) raw = 64;
            else if (raw == 1) raw = 127;
            else if (raw == 2) raw = $urandom_range(65, 126);
            else raw = $urandom_range(2, 10);
            write_count(CNT_W'(raw));
            n = raw > 64 ? 64 : raw;
            gaps_on = $urandom_range(0, 2) != 0;
            for (int p = 0; p < (n > 16 ? 1 : $urandom_range(2, 8)); p++)
            begin
                if ($urandom_range(0, 4) != 0)
                    make_perms(n, $urandom_range(0, 2) == 0);
                else
                    for (int i = 0; i < n; i++)
                    begin
                        pa[i] = GENE_W'($urandom_range(0, $urandom_range(0, 1) ? n : 63));
                        pb[i] = GENE_W'($urandom_range(0, $urandom_range(0, 1) ? n : 63));
                    end
                if ($urandom_range(0, 9) == 0)
                    send_pair(n, GENE_W'($urandom_range(n > 63 ? 63 : n, 63)),
                              CNT_W'($urandom));
                else
                    send_pair(n, GENE_W'($urandom_range(0, n - 1)),
                              CNT_W'($urandom_range(0, 4) == 0 ? $urandom_range(0, 127)
                                                               : $urandom_range(0, n)));
            end
            drain();
        end

        $display("%0d requests in %0d pairs, %0d child results (%0d flagged error)",
                 items_sent, pairs_sent, children_seen, errors_seen);
        $display("counts 2..64 with clamping, wrapped and clamped segments, map cycles covered");
        if (fails == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
rtl/pmx_pkg.sv
rtl/pmx_front.sv
rtl/pmx_job_queue.sv
rtl/pmx_back.sv
rtl/partially_mapped_crossover_unit.sv
verif/pmx_checker.sv
verif/tb_partially_mapped_crossover_unit.sv
